FILE: design/ffha_pkg.sv
package ffha_pkg;

    // Arena geometry
    localparam int INIT_BYTES   = 4096;
    localparam int HEADER_BYTES = 40;
    localparam int ALIGN_BYTES  = 8;      // power of two
    localparam int ARENA_BYTES  = 65536;
    localparam int MAX_BLOCKS   = 64;

    localparam int AW = 17;   // arena addresses, sizes, limit
    localparam int XW = 19;   // room for request plus initial size plus alignment
    localparam int DW = 16;   // data address on the stream

    localparam logic [AW-1:0] LIMIT_RESET = AW'(65536);
    localparam logic [AW-1:0] ARENA_MAX   = AW'(ARENA_BYTES);
    localparam logic [AW-1:0] HDR         = AW'(HEADER_BYTES);
    localparam logic [XW-1:0] HDR_X       = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] INIT_X      = XW'(INIT_BYTES);
    localparam logic [XW-1:0] ALIGN_MASK  = XW'(ALIGN_BYTES - 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_DOUBLE  = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef struct packed {
        logic          free;
        logic [AW-1:0] size;
        logic [AW-1:0] start;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        free:  1'b1,
        size:  AW'(INIT_BYTES - HEADER_BYTES),
        start: '0
    };

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan;
        logic    grow;
        logic    take;
        logic    merge;
        logic    shift;
        logic    wr_split;
        logic    res_we;
        status_t res_code;
        logic    out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_free;
        logic bad_addr;
        logic hit;
        logic miss;
        logic cur_free;
        logic split;
        logic grow_ok;
        logic sh_done;
    } stat_t;

    function automatic logic [XW-1:0] round_up(input logic [XW-1:0] n);
        round_up = (n + ALIGN_MASK) & ~ALIGN_MASK;
    endfunction

endpackage

FILE: design/ffha_ctrl.sv
module ffha_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ffha_pkg::stat_t      st,
    output ffha_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GROW,
        S_TAKE,
        S_FNEXT,
        S_SHIFT,
        S_SPLIT,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   grown_reg, grown_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        state_next = state_reg;
        grown_next = grown_reg;
        cmd        = '0;
        cmd.res_code = ffha_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    grown_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.bad_addr)
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_code = ffha_pkg::ST_INVALID;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (st.hit)
                        state_next = st.is_free ? S_FNEXT : S_TAKE;
                    else if (st.miss)
                    begin
                        if (st.is_free || grown_reg)
                        begin
                            cmd.res_we   = 1'b1;
                            cmd.res_code = st.is_free ? ffha_pkg::ST_INVALID
                                                      : ffha_pkg::ST_OOM;
                            state_next   = S_FIN;
                        end
                        else
                            state_next = S_GROW;
                    end
                end
            end
            S_GROW:
            begin
                if (st.grow_ok)
                begin
                    cmd.grow   = 1'b1;
                    grown_next = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_code = ffha_pkg::ST_OOM;
                    state_next   = S_FIN;
                end
            end
            S_TAKE:
            begin
                cmd.take     = 1'b1;
                cmd.res_we   = 1'b1;
                cmd.res_code = ffha_pkg::ST_OK;
                state_next   = S_SHIFT;
            end
            S_FNEXT:
            begin
                cmd.res_we = 1'b1;
                if (st.cur_free)
                begin
                    cmd.res_code = ffha_pkg::ST_DOUBLE;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.merge    = 1'b1;
                    cmd.res_code = ffha_pkg::ST_OK;
                    state_next   = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (st.sh_done)
                    state_next = st.split ? S_SPLIT : S_FIN;
            end
            S_SPLIT:
            begin
                cmd.wr_split = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            grown_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            grown_reg    <= grown_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: design/ffha_datapath.sv
module ffha_datapath
#(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [31:0]              s_tdata,
    input  logic [0:0]               s_tuser,
    input  logic                     cfg_we,
    input  logic [ffha_pkg::AW-1:0]  cfg_data,
    input  ffha_pkg::cmd_t           cmd,
    output ffha_pkg::stat_t          st,
    output logic [15:0]              m_tdata,
    output logic [1:0]               m_tuser
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = ffha_pkg::AW;
    localparam int XW = ffha_pkg::XW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    // block table
    ffha_pkg::entry_t mem [MAX_BLOCKS];
    ffha_pkg::entry_t rdata_reg;
    logic             rd0_reg;
    logic             init_reg;

    // item and table state
    logic                    op_reg;
    logic                    bad_reg;
    logic [AW-1:0]           hdr_reg;
    logic [AW-1:0]           want_reg;
    logic [XW-1:0]           ext_reg;
    logic [CW-1:0]           cnt_reg;
    logic [AW-1:0]           end_reg;
    logic [AW-1:0]           limit_reg;

    // scan
    logic [CW-1:0]           idx_reg;
    logic                    chk_vld_reg;
    logic [CW-1:0]           chk_idx_reg;
    ffha_pkg::entry_t        cur_reg, prev_reg;
    logic [CW-1:0]           cur_idx_reg;

    // shift engine
    logic [CW-1:0]           src_reg, left_reg;
    logic                    up_reg;
    logic [1:0]              r_reg;
    logic                    pend_reg;
    logic [IW-1:0]           pend_dst_reg;
    logic                    split_reg;

    // result
    logic [15:0]             res_data_reg, out_data_reg;
    ffha_pkg::status_t       res_status_reg, out_status_reg;

    ffha_pkg::entry_t        ev;
    logic                    match, last;
    logic [AW-1:0]           lim;
    logic                    split_c;
    logic                    pf, nf;
    logic [1:0]              r_c;
    logic [CW-1:0]           b_c;
    logic [XW-1:0]           msize;
    logic [AW-1:0]           mstart;
    logic                    we;
    logic [IW-1:0]           wa, ra;
    ffha_pkg::entry_t        wd;
    logic [15:0]             in_req, in_addr;

    assign in_req  = s_tdata[15:0];
    assign in_addr = s_tdata[31:16];

    assign ev    = rd0_reg ? ffha_pkg::ENTRY_RESET : rdata_reg;
    assign match = op_reg ? (ev.start == hdr_reg)
                          : (ev.free && (ev.size >= want_reg));
    assign last  = (chk_idx_reg == cnt_reg - ONE);
    assign lim   = (limit_reg < ffha_pkg::ARENA_MAX) ? limit_reg : ffha_pkg::ARENA_MAX;

    assign split_c = (XW'(cur_reg.size) > XW'(want_reg) + ffha_pkg::HDR_X)
                     && (cnt_reg < CNT_MAX);

    // merge with free neighbors: ev holds the entry after the freed one
    assign pf     = (cur_idx_reg != '0) && prev_reg.free;
    assign nf     = ((cur_idx_reg + ONE) < cnt_reg) && ev.free;
    assign r_c    = {1'b0, pf} + {1'b0, nf};
    assign b_c    = pf ? cur_idx_reg - ONE : cur_idx_reg;
    assign mstart = pf ? prev_reg.start : cur_reg.start;
    assign msize  = XW'(cur_reg.size)
                  + (pf ? XW'(prev_reg.size) + ffha_pkg::HDR_X : '0)
                  + (nf ? XW'(ev.size) + ffha_pkg::HDR_X : '0);

    always_comb
    begin
        st.is_free  = op_reg;
        st.bad_addr = op_reg && bad_reg;
        st.hit      = chk_vld_reg && match;
        st.miss     = chk_vld_reg && !match && last;
        st.cur_free = cur_reg.free;
        st.split    = split_reg;
        st.grow_ok  = (end_reg <= lim)
                      && (ext_reg <= XW'(lim - end_reg))
                      && (cur_reg.free || (cnt_reg < CNT_MAX));
        st.sh_done  = (left_reg == '0) && !pend_reg;
    end

    // table write port
    always_comb
    begin
        we = 1'b0;
        wa = cur_idx_reg[IW-1:0];
        wd = cur_reg;
        if (cmd.take)
        begin
            we = 1'b1;
            wd = '{free: 1'b0, size: split_c ? want_reg : cur_reg.size,
                   start: cur_reg.start};
        end
        else if (cmd.grow)
        begin
            we = 1'b1;
            if (cur_reg.free)
                wd = '{free: 1'b1, size: AW'(XW'(cur_reg.size) + ext_reg),
                       start: cur_reg.start};
            else
            begin
                wa = cnt_reg[IW-1:0];
                wd = '{free: 1'b1, size: AW'(ext_reg - ffha_pkg::HDR_X),
                       start: end_reg};
            end
        end
        else if (cmd.merge)
        begin
            we = 1'b1;
            wa = b_c[IW-1:0];
            wd = '{free: 1'b1, size: AW'(msize), start: mstart};
        end
        else if (cmd.wr_split)
        begin
            we = 1'b1;
            wa = IW'(cur_idx_reg + ONE);
            wd = '{free: 1'b1,
                   size: cur_reg.size - want_reg - ffha_pkg::HDR,
                   start: cur_reg.start + ffha_pkg::HDR + want_reg};
        end
        else if (cmd.shift && pend_reg)
        begin
            we = 1'b1;
            wa = pend_dst_reg;
            wd = rdata_reg;
        end
    end

    assign ra = cmd.shift ? src_reg[IW-1:0] : idx_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rdata_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= 1'b1;
            rd0_reg   <= 1'b0;
            cnt_reg   <= ONE;
            end_reg   <= AW'(ffha_pkg::INIT_BYTES);
            limit_reg <= ffha_pkg::LIMIT_RESET;
        end
        else
        begin
            rd0_reg <= (ra == '0) && init_reg;
            if (we && (wa == '0))
                init_reg <= 1'b0;
            if (cfg_we)
                limit_reg <= cfg_data;
            if (cmd.take && split_c)
                cnt_reg <= cnt_reg + ONE;
            if (cmd.grow)
            begin
                end_reg <= AW'(XW'(end_reg) + ext_reg);
                if (!cur_reg.free)
                    cnt_reg <= cnt_reg + ONE;
            end
            if (cmd.merge)
                cnt_reg <= cnt_reg - CW'(r_c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= s_tuser[0];
            want_reg    <= AW'(ffha_pkg::round_up(XW'(in_req)));
            ext_reg     <= ffha_pkg::round_up(XW'(in_req) + ffha_pkg::INIT_X);
            hdr_reg     <= AW'(in_addr) - ffha_pkg::HDR;
            bad_reg     <= (AW'(in_addr) < ffha_pkg::HDR);
            idx_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        if (cmd.grow)
        begin
            idx_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        if (cmd.scan)
        begin
            idx_reg     <= idx_reg + ONE;
            chk_vld_reg <= 1'b1;
            chk_idx_reg <= idx_reg;
            if (chk_vld_reg)
            begin
                cur_reg     <= ev;
                cur_idx_reg <= chk_idx_reg;
                prev_reg    <= cur_reg;
            end
        end
        if (cmd.take)
        begin
            split_reg <= split_c;
            left_reg  <= split_c ? cnt_reg - ONE - cur_idx_reg : '0;
            src_reg   <= cnt_reg - ONE;
            up_reg    <= 1'b1;
            r_reg     <= 2'd1;
            pend_reg  <= 1'b0;
        end
        if (cmd.merge)
        begin
            split_reg <= 1'b0;
            left_reg  <= (r_c != 2'd0) ? cnt_reg - ONE - CW'(r_c) - b_c : '0;
            src_reg   <= b_c + ONE + CW'(r_c);
            up_reg    <= 1'b0;
            r_reg     <= r_c;
            pend_reg  <= 1'b0;
        end
        if (cmd.shift)
        begin
            pend_reg <= (left_reg != '0);
            if (left_reg != '0)
            begin
                left_reg     <= left_reg - ONE;
                src_reg      <= up_reg ? src_reg - ONE : src_reg + ONE;
                pend_dst_reg <= up_reg ? IW'(src_reg + ONE) : IW'(src_reg - CW'(r_reg));
            end
        end
        if (cmd.res_we)
        begin
            res_status_reg <= cmd.res_code;
            res_data_reg   <= cmd.take ? 16'(cur_reg.start + ffha_pkg::HDR) : '0;
        end
        if (cmd.out_load)
        begin
            out_data_reg   <= res_data_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_status_reg;

endmodule

FILE: design/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing over a byte arena.
// Input stream: s_tuser[0] is the operation (0 allocate, 1 free), s_tdata
// carries the request size and the data address being freed. Every item
// yields exactly one result item: m_tdata is the data address handed out
// (0 for frees and failures), m_tuser the status (ok, out of memory,
// double free, invalid free).
// An item walks the block table one entry per cycle through the table
// memory's single read port, then shifts entries one per cycle on a split
// or merge. An allocate that has to grow the arena scans the table twice.
// The block takes one item at a time; s_tready is high only while idle.
// Reset: the table holds one free block spanning the initial arena and the
// arena limit register returns to 65536. No clearing pass is needed.
// Receiver stall: the finished result sits in an output register, so a new
// item is accepted and processed while m_tvalid waits for m_tready; the
// block only holds when a second result is ready before the first is taken.
// cfg_we/cfg_data write the arena limit; write it only while idle.
module first_fit_heap_allocator
#(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [31:0]              s_tdata,   // [15:0] request_size, [31:16] free_address
    input  logic [0:0]               s_tuser,   // [0] op
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,   // [15:0] data_address
    output logic [1:0]               m_tuser,   // [1:0] status
    input  logic                     cfg_we,
    input  logic [ffha_pkg::AW-1:0]  cfg_data   // arena_limit
);

    ffha_pkg::cmd_t  cmd;
    ffha_pkg::stat_t st;

    // sequencer: scan, grow, take or merge, shift, split write, result hand-off
    ffha_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // block table, arena registers and output register
    ffha_datapath
    #(
        .MAX_BLOCKS (MAX_BLOCKS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .st       (st),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // an accepted item leaves the block busy in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // a scan check never reports hit and miss together
    a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !(st.hit && st.miss))
        else $error("scan hit and miss at once");

    // the output register is loaded only when free or being drained
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

    // a failed result never carries an address
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ffha_pkg::ST_OK)) |-> (m_tdata == 16'd0))
        else $error("non-zero address on a failed result");

endmodule

FILE: test/first_fit_heap_allocator_test.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 200;   // room for a full-table item that grows the arena, plus margin
    localparam int RANDOM_PHASES  = 5;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int AW             = ffha_pkg::AW;
    localparam int MAX_BLOCKS     = ffha_pkg::MAX_BLOCKS;
    localparam int HDR_BYTES      = ffha_pkg::HEADER_BYTES;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;    // [15:0] request_size, [31:16] free_address
    logic [0:0]        s_tuser;    // [0] op
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;    // [15:0] data_address
    logic [1:0]        m_tuser;    // [1:0] status
    logic              cfg_we;
    logic [AW-1:0]     cfg_data;   // arena_limit

    localparam bit OP_ALLOC = 1'b0;
    localparam bit OP_FREE  = 1'b1;

    first_fit_heap_allocator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow heap: our own copy of the block table and arena registers
    // ------------------------------------------------------------------
    bit [AW-1:0] blk_base   [MAX_BLOCKS];
    bit [AW-1:0] heap_size  [MAX_BLOCKS];
    bit          heap_free  [MAX_BLOCKS];
    int          heap_count;
    int          arena_top;
    int          heap_limit;

    typedef struct {
        bit [15:0]          addr;
        ffha_pkg::status_t  status;
    } heap_result_t;

    heap_result_t pending_results [$];
    int           live_addrs [$];    // data addresses currently handed out
    int           freed_addrs [$];   // recently returned, for double frees

    int errors = 0;
    int items_sent;
    int results_seen;
    int oom_seen;
    int double_seen;
    int invalid_seen;
    int full_table_seen;
    int idle_cycles = 0;
    int rx_mode;
    int rx_tick = 0;

    function automatic void heap_reset();
        for (int k = 0; k < MAX_BLOCKS; k++)
        begin
            blk_base[k]  = '0;
            heap_size[k] = '0;
            heap_free[k] = 1'b0;
        end
        heap_size[0] = AW'(ffha_pkg::INIT_BYTES - HDR_BYTES);
        heap_free[0] = 1'b1;
        heap_count   = 1;
        arena_top    = ffha_pkg::INIT_BYTES;
        heap_limit   = 65536;
    endfunction

    function automatic int align_up(int n);
        return ((n + ffha_pkg::ALIGN_BYTES - 1) / ffha_pkg::ALIGN_BYTES) * ffha_pkg::ALIGN_BYTES;
    endfunction

    // Remove entry at, pulling the tail down by one.
    function automatic void heap_close(int at);
        for (int k = at; k + 1 < heap_count; k++)
        begin
            blk_base[k]  = blk_base[k + 1];
            heap_size[k] = heap_size[k + 1];
            heap_free[k] = heap_free[k + 1];
        end
        heap_count--;
    endfunction

    // First free block that fits; split when the rest exceeds a header.
    function automatic int heap_take(int want);
        int i;
        for (i = 0; i < heap_count; i++)
            if (heap_free[i] && heap_size[i] >= want)
                break;
        if (i >= heap_count)
            return heap_count;
        if (heap_size[i] > want + HDR_BYTES)
        begin
            if (heap_count < MAX_BLOCKS)
            begin
                for (int k = heap_count; k > i + 1; k--)
                begin
                    blk_base[k]  = blk_base[k - 1];
                    heap_size[k] = heap_size[k - 1];
                    heap_free[k] = heap_free[k - 1];
                end
                heap_count++;
                blk_base[i + 1]  = AW'(blk_base[i] + HDR_BYTES + want);
                heap_size[i + 1] = AW'(heap_size[i] - want - HDR_BYTES);
                heap_free[i + 1] = 1'b1;
                heap_size[i]     = AW'(want);
            end
            else
                full_table_seen++;
        end
        heap_free[i] = 1'b0;
        return i;
    endfunction

    function automatic bit heap_grow(int req);
        int ext;
        int lim;
        int last;
        ext  = align_up(req + ffha_pkg::INIT_BYTES);
        lim  = (heap_limit < ffha_pkg::ARENA_BYTES) ? heap_limit : ffha_pkg::ARENA_BYTES;
        last = heap_count - 1;
        if (arena_top > lim || ext > lim - arena_top)
            return 1'b0;
        if (heap_free[last])
            heap_size[last] = AW'(heap_size[last] + ext);
        else
        begin
            if (heap_count >= MAX_BLOCKS)
            begin
                full_table_seen++;
                return 1'b0;
            end
            blk_base[heap_count]  = AW'(arena_top);
            heap_size[heap_count] = AW'(ext - HDR_BYTES);
            heap_free[heap_count] = 1'b1;
            heap_count++;
        end
        arena_top += ext;
        return 1'b1;
    endfunction

    function automatic heap_result_t heap_apply(bit op, bit [15:0] req, bit [15:0] addr);
        heap_result_t r;
        int want;
        int i;
        r.addr   = '0;
        r.status = ffha_pkg::ST_OK;
        if (op == OP_ALLOC)
        begin
            want = align_up(req);
            i = heap_take(want);
            if (i >= heap_count && heap_grow(req))
                i = heap_take(want);
            if (i >= heap_count)
                r.status = ffha_pkg::ST_OOM;
            else
                r.addr = 16'(blk_base[i] + HDR_BYTES);
        end
        else
        begin
            i = heap_count;
            if (addr >= HDR_BYTES)
                for (i = 0; i < heap_count; i++)
                    if (blk_base[i] == addr - HDR_BYTES)
                        break;
            if (i >= heap_count)
                r.status = ffha_pkg::ST_INVALID;
            else if (heap_free[i])
                r.status = ffha_pkg::ST_DOUBLE;
            else
            begin
                heap_free[i] = 1'b1;
                // merge downward first, then upward
                if (i > 0 && heap_free[i - 1])
                begin
                    heap_size[i - 1] = AW'(heap_size[i - 1] + heap_size[i] + HDR_BYTES);
                    heap_close(i);
                    i--;
                end
                if (i + 1 < heap_count && heap_free[i + 1])
                begin
                    heap_size[i] = AW'(heap_size[i] + heap_size[i + 1] + HDR_BYTES);
                    heap_close(i + 1);
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, receiver stall pattern, result checker, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: mode 0 always ready, 1 coin toss, 2 fixed duty pattern
    always @(negedge clk)
    begin
        rx_tick++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(1, 0));
            default: m_tready <= ((rx_tick % 7) < 3);
        endcase
    end

    task automatic report(string what, int got, int want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    always @(posedge clk)
    begin
        heap_result_t e;
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report("unexpected result, data_address", m_tdata, 0);
            else
            begin
                e = pending_results.pop_front();
                if (m_tdata !== e.addr)
                    report("data_address", m_tdata, e.addr);
                if (m_tuser !== e.status)
                    report("status", m_tuser, e.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one item; hold it until taken, then predict. A typed expectation
    // overrides the shadow heap's answer but the heap still advances.
    task automatic send_item(bit op, bit [15:0] req, bit [15:0] addr,
                             bit typed, bit [15:0] t_addr, ffha_pkg::status_t t_status);
        heap_result_t r;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {addr, req};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        r = heap_apply(op, req, addr);
        if (typed)
        begin
            r.addr   = t_addr;
            r.status = t_status;
        end
        case (r.status)
            ffha_pkg::ST_OOM:     oom_seen++;
            ffha_pkg::ST_DOUBLE:  double_seen++;
            ffha_pkg::ST_INVALID: invalid_seen++;
            default:    ;
        endcase
        pending_results.push_back(r);
        items_sent++;
    endtask

    task automatic sender_gap(int n);
        repeat (n)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    // Hold the sender until every result is back, then let the table walk settle.
    task automatic drain();
        sender_gap(1);
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= AW'(value);
        heap_limit = value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Pick a random item; mostly live frees and small allocations.
    task automatic random_item(int small_bias);
        int pick;
        int idx;
        bit [15:0] req;
        bit [15:0] addr;
        heap_result_t r;
        pick = $urandom_range(99, 0);
        req  = '0;
        addr = '0;
        if (pick < 55 + small_bias || live_addrs.size() == 0)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
                req = 16'($urandom_range(128, 0));
            else if (pick < 95)
                req = 16'($urandom_range(4096, 0));
            else
                req = 16'($urandom_range(16'hFFFF, 0));
            send_item(OP_ALLOC, req, 16'($urandom()), 1'b0, '0, ffha_pkg::ST_OK);
            r = pending_results[$];
            if (r.status == ffha_pkg::ST_OK)
                live_addrs.push_back(r.addr);
        end
        else
        begin
            pick = $urandom_range(99, 0);
            req  = 16'($urandom());
            if (pick < 75)
            begin
                idx  = $urandom_range(live_addrs.size() - 1, 0);
                addr = 16'(live_addrs[idx]);
                live_addrs.delete(idx);
                freed_addrs.push_back(addr);
                if (freed_addrs.size() > 16)
                    void'(freed_addrs.pop_front());
            end
            else if (pick < 87 && freed_addrs.size() > 0)
                addr = 16'(freed_addrs[$urandom_range(freed_addrs.size() - 1, 0)]);
            else if (pick < 93)
                addr = 16'($urandom_range(HDR_BYTES - 1, 0));
            else
                addr = 16'($urandom());
            send_item(OP_FREE, req, addr, 1'b0, '0, ffha_pkg::ST_OK);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table: op, request_size, free_address, typed?, data, status
    // ------------------------------------------------------------------
    typedef struct {
        bit                 op;
        bit [15:0]          req;
        bit [15:0]          addr;
        bit                 typed;
        bit [15:0]          d;
        ffha_pkg::status_t  st;
    } stim_row_t;

    localparam int DIR_ROWS = 23;
    stim_row_t dir_table [DIR_ROWS] = '{
        '{OP_ALLOC, 16'd0,     16'd0,     1'b1, 16'd40, ffha_pkg::ST_OK},      // zero size, split
        '{OP_FREE,  16'd0,     16'd0,     1'b1, 16'd0,  ffha_pkg::ST_INVALID}, // below header
        '{OP_FREE,  16'hFFFF,  16'd39,    1'b1, 16'd0,  ffha_pkg::ST_INVALID}, // just below header
        '{OP_FREE,  16'd0,     16'd40,    1'b1, 16'd0,  ffha_pkg::ST_OK},      // merge with tail
        '{OP_FREE,  16'd0,     16'd40,    1'b1, 16'd0,  ffha_pkg::ST_DOUBLE},
        '{OP_FREE,  16'd0,     16'hFFFF,  1'b1, 16'd0,  ffha_pkg::ST_INVALID}, // unknown address
        '{OP_ALLOC, 16'hFFFF,  16'hFFFF,  1'b1, 16'd0,  ffha_pkg::ST_OOM},     // growth past limit
        '{OP_ALLOC, 16'd4056,  16'd0,     1'b0, 16'd0,  ffha_pkg::ST_OK},      // exact fit, no split
        '{OP_ALLOC, 16'd1,     16'd0,     1'b0, 16'd0,  ffha_pkg::ST_OK},      // grow, append block
        '{OP_ALLOC, 16'd7,     16'd0,     1'b0, 16'd0,  ffha_pkg::ST_OK},
        '{OP_ALLOC, 16'd13,    16'd0,     1'b0, 16'd0,  ffha_pkg::ST_OK},
        '{OP_ALLOC, 16'hFFFF,  16'd0,     1'b1, 16'd0,  ffha_pkg::ST_OOM},
        '{OP_FREE,  16'd0,     16'd4136,  1'b0, 16'd0,  ffha_pkg::ST_OK},
        '{OP_FREE,  16'd0,     16'd4232,  1'b0, 16'd0,  ffha_pkg::ST_OK},      // merge with free tail
        '{OP_FREE,  16'd0,     16'd4184,  1'b0, 16'd0,  ffha_pkg::ST_OK},      // merge both sides
        '{OP_FREE,  16'd0,     16'd4232,  1'b0, 16'd0,  ffha_pkg::ST_OK},      // absorbed header
        '{OP_ALLOC, 16'd8000,  16'd0,     1'b0, 16'd0,  ffha_pkg::ST_OK},      // grow a free tail
        '{OP_ALLOC, 16'd41,    16'd0,     1'b0, 16'd0,  ffha_pkg::ST_OK},
        '{OP_FREE,  16'd0,     16'd40,    1'b0, 16'd0,  ffha_pkg::ST_OK},
        '{OP_ALLOC, 16'd4016,  16'd0,     1'b0, 16'd0,  ffha_pkg::ST_OK},      // rest equals header
        '{OP_ALLOC, 16'd32768, 16'h8000,  1'b0, 16'd0,  ffha_pkg::ST_OK},
        '{OP_FREE,  16'd0,     16'hAAAA,  1'b0, 16'd0,  ffha_pkg::ST_OK},
        '{OP_FREE,  16'd0,     16'h5555,  1'b0, 16'd0,  ffha_pkg::ST_OK}
    };

    int phase_limits [RANDOM_PHASES];

    initial
    begin
        int burst;
        heap_result_t r;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        rx_mode  = 0;
        heap_reset();

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows run against the reset limit
        rx_mode = 2;
        foreach (dir_table[n])
        begin
            send_item(dir_table[n].op, dir_table[n].req, dir_table[n].addr,
                      dir_table[n].typed, dir_table[n].d, dir_table[n].st);
            r = pending_results[$];
            if (dir_table[n].op == OP_ALLOC && r.status == ffha_pkg::ST_OK)
                live_addrs.push_back(r.addr);
            if (n % 3 == 0)
                sender_gap($urandom_range(4, 1));
        end
        drain();

        // Limit settings: top of range, minimum (below end), a random one,
        // the full register width, and a random aligned one
        phase_limits[0] = 65536;
        phase_limits[1] = 4096;
        phase_limits[2] = $urandom_range(65536, 4096);
        phase_limits[3] = 131071;
        phase_limits[4] = 4096 + 8 * $urandom_range(2000, 0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_limit(phase_limits[ph]);
            rx_mode = ph % 3;
            for (int n = 0; n < ITEMS_PER_PHASE; n += burst)
            begin
                burst = $urandom_range(20, 1);
                // lean toward allocation in odd phases to fill the table
                repeat (burst)
                    random_item((ph % 2) ? 25 : 0);
                if ($urandom_range(3, 0) != 0)
                    sender_gap($urandom_range(8, 1));
            end
            drain();
        end

        $display("Covered %0d items, %0d results: %0d out of memory, %0d double, %0d invalid",
                 items_sent, results_seen, oom_seen, double_seen, invalid_seen);
        $display("Full-table splits or growths skipped: %0d over %0d limit settings",
                 full_table_seen, RANDOM_PHASES + 1);
        if (errors == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
